[sv/roc_pkg.sv]
// ----------------------------------------------------------------------------
// roc_pkg
// Shared widths and stage payload types for the RGBA "over" compositor.
// ----------------------------------------------------------------------------
package roc_pkg;

  localparam int ChW        = 8;              // one color or alpha channel
  localparam int NumCh      = 3;              // red, green, blue
  localparam int NumW       = 2 * ChW + 1;    // fa*fc + w*bc
  localparam int InW        = 8 * ChW;        // packed input transfer
  localparam int OutW       = 4 * ChW;        // packed output transfer
  localparam int DivPerStg  = 2;              // quotient bits per divider stage
  localparam int DivStages  = ChW / DivPerStg;

  localparam logic [ChW-1:0] ChMax = {ChW{1'b1}};

  typedef logic [ChW-1:0]  ch_t;
  typedef logic [NumW-1:0] num_t;

  typedef struct packed {
    ch_t [NumCh-1:0] fg_c;   // index 0 red, 1 green, 2 blue
    ch_t             fa;
    ch_t [NumCh-1:0] bg_c;
    ch_t             ba;
  } pix_t;

  typedef struct packed {
    ch_t [NumCh-1:0] fg_c;
    ch_t             fa;
    ch_t [NumCh-1:0] bg_c;
    ch_t             ba;
    ch_t             w;      // weighted background alpha
  } wgt_t;

  typedef struct packed {
    num_t [NumCh-1:0] rem;   // partial remainder
    ch_t              dvs;   // divisor, never zero
    ch_t  [NumCh-1:0] quo;   // quotient bits found so far
    ch_t              alpha; // output alpha
  } div_t;

endpackage

[sv/rgba_over_compositor.sv]
// ----------------------------------------------------------------------------
// rgba_over_compositor
// Porter-Duff "over" of a straight-alpha RGBA8888 foreground pixel onto a
// background pixel, normalized by the output alpha.
//
//   channel | dir | width | content
//   --------+-----+-------+------------------------------------------------
//   in_     | in  |  64   | fg r,g,b,a then bg r,g,b,a, 8 bits each
//   out_    | out |  32   | r,g,b,a, 8 bits each
//
// One pixel per clock sustained while out_tready stays high; stages are weight, mix
// and four 2-bit restoring divider stages (the last stage is the output register).
// Each stage loads whenever it is empty or its successor takes its transfer,
// so bubbles are squeezed out and a stall loses nothing.
// rst_n clears the stage valid bits only; no state is kept between pixels.
// ----------------------------------------------------------------------------
module rgba_over_compositor
  import roc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [InW-1:0]  in_tdata,   // fg_red, fg_green, fg_blue, fg_alpha,
                                      // bg_red, bg_green, bg_blue, bg_alpha
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OutW-1:0] out_tdata   // out_red, out_green, out_blue, out_alpha
);

  pix_t pix;
  logic w_vld;
  logic w_rdy;
  wgt_t w_dat;

  logic [DivStages:0] d_vld;
  logic [DivStages:0] d_rdy;
  div_t               d_dat [DivStages+1];

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      pix.fg_c[c] = in_tdata[c*ChW +: ChW];
      pix.bg_c[c] = in_tdata[(c+4)*ChW +: ChW];
    end
    pix.fa = in_tdata[3*ChW +: ChW];
    pix.ba = in_tdata[7*ChW +: ChW];
  end

  roc_weight u_weight (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (in_tvalid),
    .rdy_o (in_tready),
    .dat_i (pix),
    .vld_o (w_vld),
    .rdy_i (w_rdy),
    .dat_o (w_dat)
  );

  roc_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (w_vld),
    .rdy_o (w_rdy),
    .dat_i (w_dat),
    .vld_o (d_vld[0]),
    .rdy_i (d_rdy[0]),
    .dat_o (d_dat[0])
  );

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    roc_div_stage #(
      .BIT_HI (ChW - 1 - g * DivPerStg)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (d_vld[g]),
      .rdy_o (d_rdy[g]),
      .dat_i (d_dat[g]),
      .vld_o (d_vld[g+1]),
      .rdy_i (d_rdy[g+1]),
      .dat_o (d_dat[g+1])
    );
  end

  assign d_rdy[DivStages] = out_tready;
  assign out_tvalid       = d_vld[DivStages];
  assign out_tdata        = {d_dat[DivStages].alpha,
                             d_dat[DivStages].quo[2],
                             d_dat[DivStages].quo[1],
                             d_dat[DivStages].quo[0]};

endmodule

[sv/roc_weight.sv]
// ----------------------------------------------------------------------------
// roc_weight
// Stage 1: weighted background alpha w = floor(ba * (255 - fa) / 255).
// ----------------------------------------------------------------------------
module roc_weight
  import roc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  output logic rdy_o,
  input  pix_t dat_i,
  output logic vld_o,
  input  logic rdy_i,
  output wgt_t dat_o
);

  logic              vld_r;
  wgt_t              dat_r;
  wgt_t              dat_nxt;
  logic [2*ChW-1:0]  prod;
  logic [2*ChW-1:0]  sum;

  assign rdy_o = !vld_r || rdy_i;

  // x / 255 for 16-bit x: (x + (x >> 8) + 1) >> 8
  always_comb begin
    prod = dat_i.ba * (ChMax - dat_i.fa);
    sum  = prod + (prod >> ChW) + (2*ChW)'(1);
    dat_nxt.fg_c = dat_i.fg_c;
    dat_nxt.fa   = dat_i.fa;
    dat_nxt.bg_c = dat_i.bg_c;
    dat_nxt.ba   = dat_i.ba;
    dat_nxt.w    = sum[2*ChW-1:ChW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

  a_w_le_ba: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> dat_r.w <= dat_r.ba)
    else $error("weighted alpha exceeds background alpha");

  a_oa_fits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> ({1'b0, dat_r.fa} + {1'b0, dat_r.w}) <= {1'b0, ChMax})
    else $error("output alpha overflows");

endmodule

[sv/roc_mix.sv]
// ----------------------------------------------------------------------------
// roc_mix
// Stage 2: output alpha and weighted channel sums, divider setup.
// ----------------------------------------------------------------------------
module roc_mix
  import roc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  output logic rdy_o,
  input  wgt_t dat_i,
  output logic vld_o,
  input  logic rdy_i,
  output div_t dat_o
);

  logic vld_r;
  div_t dat_r;
  div_t dat_nxt;
  ch_t  oa;
  logic transp;

  assign rdy_o = !vld_r || rdy_i;

  // transparent fg: background passes through as bc / 1, alpha = ba = fa + w
  always_comb begin
    oa     = dat_i.fa + dat_i.w;
    transp = (dat_i.fa == '0);
    dat_nxt.alpha = oa;
    dat_nxt.quo   = '0;
    dat_nxt.dvs   = transp ? ch_t'(1) : oa;
    for (int c = 0; c < NumCh; c++) begin
      if (transp) begin
        dat_nxt.rem[c] = NumW'(dat_i.bg_c[c]);
      end else begin
        dat_nxt.rem[c] = (NumW'(dat_i.fa) * NumW'(dat_i.fg_c[c])) +
                         (NumW'(dat_i.w) * NumW'(dat_i.bg_c[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

  a_dvs_nz: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> dat_r.dvs != '0)
    else $error("zero divisor entered divider");

endmodule

[sv/roc_div_stage.sv]
// ----------------------------------------------------------------------------
// roc_div_stage
// Restoring divider stage: resolves quotient bits BIT_HI down to
// BIT_HI-DivPerStg+1 for all three channels.
// ----------------------------------------------------------------------------
module roc_div_stage
  import roc_pkg::*;
#(
  parameter int BIT_HI = ChW - 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  output logic rdy_o,
  input  div_t dat_i,
  output logic vld_o,
  input  logic rdy_i,
  output div_t dat_o
);

  localparam int BitLo = BIT_HI - DivPerStg + 1;

  logic vld_r;
  div_t dat_r;
  div_t dat_nxt;
  num_t r;
  num_t sh;
  ch_t  q;

  assign rdy_o = !vld_r || rdy_i;

  always_comb begin
    r   = '0;
    sh  = '0;
    q   = '0;
    dat_nxt = dat_i;
    for (int c = 0; c < NumCh; c++) begin
      r = dat_i.rem[c];
      q = dat_i.quo[c];
      for (int b = 0; b < DivPerStg; b++) begin
        sh = NumW'(dat_i.dvs) << (BIT_HI - b);
        if (r >= sh) begin
          r = r - sh;
          q[BIT_HI - b] = 1'b1;
        end
      end
      dat_nxt.rem[c] = r;
      dat_nxt.quo[c] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (dat_r.rem[0] < (NumW'(dat_r.dvs) << BitLo)) &&
              (dat_r.rem[1] < (NumW'(dat_r.dvs) << BitLo)) &&
              (dat_r.rem[2] < (NumW'(dat_r.dvs) << BitLo)))
    else $error("partial remainder out of range");

endmodule

[tb/sv/rgba_over_compositor_tb.sv]
// ----------------------------------------------------------------------------
// rgba_over_compositor_tb
// Self-checking bench for the RGBA "over" compositor. A driver streams
// foreground/background pixel pairs from a queue, each accepted transfer is
// run through a local blend predictor, and a monitor compares every output
// transfer channel by channel against the oldest predicted pixel. Directed
// alpha corner cases come first, then random pairs under varying
// backpressure, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module rgba_over_compositor_tb
  import roc_pkg::*;
();

  typedef struct packed {
    ch_t a;
    ch_t b;
    ch_t g;
    ch_t r;
  } rgba_t;

  typedef struct packed {
    rgba_t bg;
    rgba_t fg;
  } pix_pair_t;

  localparam int NumDirected = 16;
  localparam int NumRandom   = 1834;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [InW-1:0]  in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OutW-1:0] out_tdata;

  pix_pair_t pair_pending[$];
  rgba_t     blend_expected[$];
  int        sent_cnt = 0;
  int        fail_cnt = 0;
  logic      in_took = 1'b0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;

  rgba_over_compositor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic rgba_t over_blend(input pix_pair_t p);
    int unsigned fa;
    int unsigned wgt;
    int unsigned oa;
    rgba_t       res;
    if (p.fg.a == '0) begin
      return p.bg;
    end
    fa  = p.fg.a;
    wgt = (int'(p.bg.a) * (int'(ChMax) - fa)) / int'(ChMax);
    oa  = fa + wgt;
    res.r = ch_t'((fa * p.fg.r + wgt * p.bg.r) / oa);
    res.g = ch_t'((fa * p.fg.g + wgt * p.bg.g) / oa);
    res.b = ch_t'((fa * p.fg.b + wgt * p.bg.b) / oa);
    res.a = ch_t'(oa);
    return res;
  endfunction

  function automatic pix_pair_t make_pair(input ch_t fr, input ch_t fgr, input ch_t fb,
                                          input ch_t fa, input ch_t br, input ch_t bgr,
                                          input ch_t bb, input ch_t ba);
    pix_pair_t p;
    p.fg = '{a: fa, b: fb, g: fgr, r: fr};
    p.bg = '{a: ba, b: bb, g: bgr, r: br};
    return p;
  endfunction

  function automatic ch_t pick_alpha();
    case ($urandom_range(3))
      0:       return ch_t'(0);
      1:       return ch_t'(1);
      2:       return ch_t'(254);
      default: return ChMax;
    endcase
  endfunction

  function automatic int tx_idle_pct();
    if (sent_cnt < 620) return 12;
    if (sent_cnt < 1240) return 56;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (sent_cnt < 620) return 56;
    if (sent_cnt < 1240) return 12;
    return 0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, exp_val);
    fail_cnt++;
  endtask

  // input side: record accepted transfer and predict its blend
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        blend_expected.push_back(over_blend(pix_pair_t'(in_tdata)));
        void'(pair_pending.pop_front());
        sent_cnt++;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_took) begin
      if (pair_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct()) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pair_pending[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the pipeline fills and stalls the input
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && sent_cnt >= 1260) begin
        hold_left <= 90;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct());
    end
  end

  // monitor
  always @(posedge clk) begin
    rgba_t got;
    rgba_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      got = rgba_t'(out_tdata);
      if (blend_expected.size() == 0) begin
        report_mismatch("out_tdata with nothing pending", int'(out_tdata), 0);
      end else begin
        exp_px = blend_expected.pop_front();
        if (got.r !== exp_px.r) report_mismatch("out_red", got.r, exp_px.r);
        if (got.g !== exp_px.g) report_mismatch("out_green", got.g, exp_px.g);
        if (got.b !== exp_px.b) report_mismatch("out_blue", got.b, exp_px.b);
        if (got.a !== exp_px.a) report_mismatch("out_alpha", got.a, exp_px.a);
      end
    end
  end

  initial begin
    pix_pair_t p;
    // directed: transparent fg, opaque fg/bg, alpha extremes, bit patterns
    pair_pending.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pair_pending.push_back(make_pair(255, 255, 255, 255, 255, 255, 255, 255));
    pair_pending.push_back(make_pair(200, 100, 50, 0, 12, 34, 56, 78));
    pair_pending.push_back(make_pair(255, 255, 255, 0, 255, 255, 255, 255));
    pair_pending.push_back(make_pair(9, 8, 7, 0, 90, 80, 70, 0));
    pair_pending.push_back(make_pair(17, 130, 240, 255, 3, 99, 201, 255));
    pair_pending.push_back(make_pair(17, 130, 240, 255, 3, 99, 201, 0));
    pair_pending.push_back(make_pair(255, 0, 128, 1, 0, 255, 127, 0));
    pair_pending.push_back(make_pair(255, 0, 128, 1, 0, 255, 127, 255));
    pair_pending.push_back(make_pair(255, 0, 128, 254, 0, 255, 127, 255));
    pair_pending.push_back(make_pair(60, 180, 220, 128, 240, 20, 100, 128));
    pair_pending.push_back(make_pair(255, 255, 255, 1, 255, 255, 255, 1));
    pair_pending.push_back(make_pair(255, 255, 255, 100, 0, 0, 0, 200));
    pair_pending.push_back(make_pair(0, 0, 0, 100, 255, 255, 255, 200));
    pair_pending.push_back(make_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA));
    pair_pending.push_back(make_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55));
    for (int i = 0; i < NumRandom; i++) begin
      p = pix_pair_t'({$urandom(), $urandom()});
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(1)) p.fg.a = pick_alpha();
        else p.bg.a = pick_alpha();
      end
      pair_pending.push_back(p);
    end

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    while (pair_pending.size() != 0 || blend_expected.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("rgba_over_compositor test passed");
    end else begin
      $display("rgba_over_compositor test failed");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("rgba_over_compositor test failed");
    $finish;
  end

endmodule
